// ----- src/pci_pkg.sv -----
// pci_pkg: widths, register indexes and reset values shared by the
// clamped-integral pid unit
// no dependencies
package pci_pkg;

   // field and register widths
   localparam int ERR_W  = 17;          // error sample, signed q8.8
   localparam int GAIN_W = 16;          // gains, unsigned fixed point
   localparam int LIM_W  = 22;          // limits, unsigned q14.8
   localparam int OUT_W  = 23;          // drive output, signed q14.8
   localparam int INT_W  = LIM_W + 1;   // clamped integral, signed
   localparam int IDX_W  = 3;           // csr register index

   // product and accumulator widths (gain is zero-extended to signed)
   localparam int DIFF_W  = ERR_W + 1;
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + INT_W;
   localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
   localparam int ACC_W    = PROD_I_W + 2;

   // default gain fraction bits
   localparam int GAIN_FRAC_BITS_DEFAULT = 12;

   // csr register indexes
   localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
   localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
   localparam logic [IDX_W-1:0] REG_INT_LIMIT = 3'd3;
   localparam logic [IDX_W-1:0] REG_OUT_LIMIT = 3'd4;

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_P_RESET    = 16'd16384;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET    = 16'd41;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET    = 16'd2048;
   localparam logic [LIM_W-1:0]  INT_LIMIT_RESET = 22'd76800;
   localparam logic [LIM_W-1:0]  OUT_LIMIT_RESET = 22'd768000;

endpackage

// ----- src/pid_clamped_integral_unit.sv -----
// pid_clamped_integral_unit: positional pid step with clamped integral
// depends on pci_pkg
//
// usage
//   req channel (valid/ready) carries one signed q8.8 heading error per
//   transaction. rsp channel (valid/ready) returns one signed q14.8 drive
//   value per transaction, in order: the negated, output-clamped sum
//   kp*e + ki*I + kd*(e - previous e).
//   csr port: write enable, index and data; gains 0..2, integral limit 3,
//   output limit 4. writes take effect at once; write only while idle.
// timing
//   three register stages: integral update, products, sum/round/clamp.
//   a result passes the stage 1, stage 2 and output registers before
//   rsp_valid rises; one transaction per cycle is sustained while
//   rsp_ready stays high. the loop that sets the rate is the integral
//   add-and-clamp, which closes through the integral register alone.
// reset
//   synchronous reset empties the pipeline, zeroes the integral and the
//   previous error and loads the default gains and limits.
// stall
//   when rsp_ready is low the result holds in the output register; the
//   earlier stages keep filling, and req_ready drops once all are full.
module pid_clamped_integral_unit
   import pci_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [ERR_W-1:0] req_error_in,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_drive_out,
   // configuration port
   input  logic                    csr_write,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [LIM_W-1:0]        csr_wdata
);

   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(64'sd1 <<< (GAIN_FRAC_BITS - 1));

   // configuration registers
   logic [GAIN_W-1:0] gain_p_ff, gain_p_in;
   logic [GAIN_W-1:0] gain_i_ff, gain_i_in;
   logic [GAIN_W-1:0] gain_d_ff, gain_d_in;
   logic [LIM_W-1:0]  int_limit_ff, int_limit_in;
   logic [LIM_W-1:0]  out_limit_ff, out_limit_in;

   // controller state
   logic signed [INT_W-1:0] integral_ff, integral_in;
   logic signed [ERR_W-1:0] prev_error_ff, prev_error_in;

   // pipeline valid bits
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // stage 1 payload
   logic signed [ERR_W-1:0]  s1_error_ff, s1_error_in;
   logic signed [INT_W-1:0]  s1_integral_ff, s1_integral_in;
   logic signed [DIFF_W-1:0] s1_diff_ff, s1_diff_in;

   // stage 2 payload
   logic signed [PROD_P_W-1:0] s2_prod_p_ff, s2_prod_p_in;
   logic signed [PROD_I_W-1:0] s2_prod_i_ff, s2_prod_i_in;
   logic signed [PROD_D_W-1:0] s2_prod_d_ff, s2_prod_d_in;

   // output payload
   logic signed [OUT_W-1:0] rsp_drive_ff, rsp_drive_in;

   // stage advance
   logic s3_adv, s2_adv, s1_adv, req_fire;

   // datapath temporaries
   logic signed [INT_W:0]   int_sum;
   logic signed [INT_W:0]   int_lim;
   logic signed [ACC_W-1:0] acc_sum;
   logic signed [ACC_W-1:0] acc_scaled;
   logic signed [ACC_W-1:0] acc_lim;
   logic signed [ACC_W-1:0] acc_clamped;

   // handshake and stage advance
   assign s3_adv    = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;
   assign req_fire  = req_valid && s1_adv;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_out = rsp_drive_ff;

   // csr writes
   always_comb begin
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      int_limit_in = int_limit_ff;
      out_limit_in = out_limit_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GAIN_P:    gain_p_in    = csr_wdata[GAIN_W-1:0];
            REG_GAIN_I:    gain_i_in    = csr_wdata[GAIN_W-1:0];
            REG_GAIN_D:    gain_d_in    = csr_wdata[GAIN_W-1:0];
            REG_INT_LIMIT: int_limit_in = csr_wdata;
            REG_OUT_LIMIT: out_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: integral add and clamp, derivative difference
   always_comb begin
      int_sum = (INT_W + 1)'(integral_ff) + (INT_W + 1)'(req_error_in);
      int_lim = $signed((INT_W + 1)'(int_limit_ff));
      if (int_sum > int_lim) begin
         s1_integral_in = int_lim[INT_W-1:0];
      end else if (int_sum < -int_lim) begin
         s1_integral_in = INT_W'(-int_lim);
      end else begin
         s1_integral_in = int_sum[INT_W-1:0];
      end
      s1_error_in   = req_error_in;
      s1_diff_in    = DIFF_W'(req_error_in) - DIFF_W'(prev_error_ff);
      integral_in   = req_fire ? s1_integral_in : integral_ff;
      prev_error_in = req_fire ? req_error_in : prev_error_ff;
      s1_valid_in   = s1_adv ? req_valid : s1_valid_ff;
   end

   // stage 2: the three gain products
   always_comb begin
      s2_prod_p_in = PROD_P_W'($signed({1'b0, gain_p_ff})) * PROD_P_W'(s1_error_ff);
      s2_prod_i_in = PROD_I_W'($signed({1'b0, gain_i_ff})) * PROD_I_W'(s1_integral_ff);
      s2_prod_d_in = PROD_D_W'($signed({1'b0, gain_d_ff})) * PROD_D_W'(s1_diff_ff);
      s2_valid_in  = s2_adv ? s1_valid_ff : s2_valid_ff;
   end

   // stage 3: sum, round half up, clamp to output limit, negate
   always_comb begin
      acc_sum = ACC_W'(s2_prod_p_ff) + ACC_W'(s2_prod_i_ff)
              + ACC_W'(s2_prod_d_ff) + ROUND_HALF;
      acc_scaled = acc_sum >>> GAIN_FRAC_BITS;
      acc_lim    = $signed(ACC_W'(out_limit_ff));
      if (acc_scaled > acc_lim) begin
         acc_clamped = acc_lim;
      end else if (acc_scaled < -acc_lim) begin
         acc_clamped = -acc_lim;
      end else begin
         acc_clamped = acc_scaled;
      end
      rsp_drive_in = OUT_W'(-acc_clamped);
      rsp_valid_in = s3_adv ? s2_valid_ff : rsp_valid_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= GAIN_P_RESET;
         gain_i_ff     <= GAIN_I_RESET;
         gain_d_ff     <= GAIN_D_RESET;
         int_limit_ff  <= INT_LIMIT_RESET;
         out_limit_ff  <= OUT_LIMIT_RESET;
         integral_ff   <= '0;
         prev_error_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         int_limit_ff  <= int_limit_in;
         out_limit_ff  <= out_limit_in;
         integral_ff   <= integral_in;
         prev_error_ff <= prev_error_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, loaded as each stage advances
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_error_ff    <= s1_error_in;
         s1_integral_ff <= s1_integral_in;
         s1_diff_ff     <= s1_diff_in;
      end
      if (s2_adv && s1_valid_ff) begin
         s2_prod_p_ff <= s2_prod_p_in;
         s2_prod_i_ff <= s2_prod_i_in;
         s2_prod_d_ff <= s2_prod_d_in;
      end
      if (s3_adv && s2_valid_ff) begin
         rsp_drive_ff <= rsp_drive_in;
      end
   end

   // integral stays inside the limit after each accepted transaction
   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      req_fire |=>
         ((INT_W + 1)'(integral_ff) <= $signed((INT_W + 1)'($past(int_limit_ff)))) &&
         ((INT_W + 1)'(integral_ff) >= -$signed((INT_W + 1)'($past(int_limit_ff)))))
      else $error("integral outside its limit");

   // a pending result never exceeds the output limit in magnitude
   a_drive_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (ACC_W'(rsp_drive_ff) <= $signed(ACC_W'(out_limit_ff))) &&
         (ACC_W'(rsp_drive_ff) >= -$signed(ACC_W'(out_limit_ff))))
      else $error("drive outside output limit");

   // an empty pipeline always takes a transaction
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !s2_valid_ff && !rsp_valid_ff) |-> req_ready)
      else $error("req_ready low with empty pipeline");

   // a stalled first stage keeps the integral unchanged
   a_integral_holds: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> integral_ff == $past(integral_ff))
      else $error("integral moved without a transaction");

endmodule
